/* hdl/radix_integer_to_ascii_assert.svh */
// Assertion macros for the checker file.
`ifndef RADIX_INTEGER_TO_ASCII_ASSERT_SVH
`define RADIX_INTEGER_TO_ASCII_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define RITOA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, masked while reset is asserted.
`define RITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* hdl/ritoa_pkg.sv */
`default_nettype none

package ritoa_pkg;

    // Fixed field widths
    localparam int VALUE_W = 64;
    localparam int BASE_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 7;
    localparam int CAP_W   = 8;

    // Quotient bits resolved per divider cycle
    localparam int STEP_BITS = 4;

    localparam logic [BASE_W-1:0]  BASE_MIN    = 6'd2;
    localparam logic [BASE_W-1:0]  BASE_MAX    = 6'd36;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT   = 6'd10;
    localparam logic [CAP_W-1:0]   CAP_RESET   = 8'd66;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = 8'h37;  // '7', so 10 maps to 'A'
    localparam logic [CHAR_W-1:0]  CHAR_LET_A  = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0]  CHAR_LET_Z  = 8'h5A;  // 'Z'
    localparam logic [CHAR_W-1:0]  CHAR_NINE   = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0]  CHAR_NONE   = 8'h00;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic div_step;
        logic idx_init;
        logic rd_en;
        logic emit_digit;
        logic emit_error;
    } ritoa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic base_ok;
        logic div_last;
        logic quot_zero;
        logic fits;
        logic idx_zero;
        logic out_free;
    } ritoa_sts_t;

    // Digit value to ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_LIMIT)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_ALPHA + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/ritoa_if.sv */
`default_nettype none

// Input item channel
interface ritoa_in_if;
    logic                               valid;
    logic                               ready;
    logic [ritoa_pkg::VALUE_W-1:0]      value;
    logic                               is_signed;
    logic [ritoa_pkg::BASE_W-1:0]       base;

    modport source (output valid, output value, output is_signed, output base, input ready);
    modport sink   (input valid, input value, input is_signed, input base, output ready);
endinterface

// Result channel, one character per transfer
interface ritoa_out_if;
    logic                               valid;
    logic                               ready;
    logic [ritoa_pkg::CHAR_W-1:0]       ch;
    logic                               negative;
    logic                               last;
    logic                               error;
    logic [ritoa_pkg::LEN_W-1:0]        length;

    modport source (output valid, output ch, output negative, output last, output error,
                    output length, input ready);
    modport sink   (input valid, input ch, input negative, input last, input error,
                    input length, output ready);
endinterface

`default_nettype wire

/* hdl/ritoa_dp.sv */
`default_nettype none

module ritoa_dp #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ritoa_pkg::ritoa_cmd_t          cmd,
    output ritoa_pkg::ritoa_sts_t               sts,
    input  wire logic [ritoa_pkg::VALUE_W-1:0]  item_value,
    input  wire logic                           item_is_signed,
    input  wire logic [ritoa_pkg::BASE_W-1:0]   item_base,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ritoa_pkg::CAP_W-1:0]    cfg_wr_data,
    ritoa_out_if.source                         result
);

    // Dividend register padded to a whole number of divider steps
    localparam int WPAD   = ((VALUE_BITS + ritoa_pkg::STEP_BITS - 1) / ritoa_pkg::STEP_BITS)
                            * ritoa_pkg::STEP_BITS;
    localparam int ITERS  = WPAD / ritoa_pkg::STEP_BITS;
    localparam int ITER_W = (ITERS > 1) ? $clog2(ITERS) : 1;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0]              vm;
    logic                               in_neg;
    logic [VALUE_BITS-1:0]              mag;

    logic [WPAD-1:0]                    d_reg;
    logic [ritoa_pkg::DIGIT_W-1:0]      rem_reg;
    logic [ritoa_pkg::BASE_W-1:0]       base_reg;
    logic                               neg_reg;
    logic [ITER_W-1:0]                  iter_reg;
    logic [CNT_W-1:0]                   cnt_reg;
    logic [ADDR_W-1:0]                  idx_reg;
    logic [ritoa_pkg::CAP_W-1:0]        cap_reg;
    logic [ritoa_pkg::DIGIT_W-1:0]      rd_data_reg;

    logic [ritoa_pkg::DIGIT_W-1:0]      digit_mem [VALUE_BITS];

    logic                               out_valid_reg;
    logic [ritoa_pkg::CHAR_W-1:0]       out_ch_reg;
    logic                               out_neg_reg;
    logic                               out_last_reg;
    logic                               out_err_reg;
    logic [ritoa_pkg::LEN_W-1:0]        out_len_reg;

    logic [ritoa_pkg::DIGIT_W:0]        trial;
    logic [ritoa_pkg::DIGIT_W-1:0]      r_step;
    logic [WPAD-1:0]                    q_step;
    logic                               div_last;
    logic [ritoa_pkg::LEN_W-1:0]        len;
    logic                               out_free;

    // Magnitude of the incoming value
    always_comb
    begin
        vm     = item_value[VALUE_BITS-1:0];
        in_neg = item_is_signed & vm[VALUE_BITS-1];
        mag    = in_neg ? (~vm + 1'b1) : vm;
    end

    // Restoring divide, STEP_BITS quotient bits per cycle
    always_comb
    begin
        r_step = rem_reg;
        q_step = d_reg;
        trial  = '0;
        for (int i = 0; i < ritoa_pkg::STEP_BITS; i++)
        begin
            trial  = {r_step, q_step[WPAD-1]};
            q_step = {q_step[WPAD-2:0], 1'b0};
            if (trial >= {1'b0, base_reg})
            begin
                trial     = trial - {1'b0, base_reg};
                q_step[0] = 1'b1;
            end
            r_step = trial[ritoa_pkg::DIGIT_W-1:0];
        end
    end

    assign div_last = (iter_reg == ITER_W'(ITERS - 1));
    assign len      = ritoa_pkg::LEN_W'(cnt_reg) + ritoa_pkg::LEN_W'(neg_reg);
    assign out_free = !out_valid_reg || result.ready;

    // Status back to the controller
    always_comb
    begin
        sts.base_ok   = (item_base >= ritoa_pkg::BASE_MIN) && (item_base <= ritoa_pkg::BASE_MAX);
        sts.div_last  = div_last;
        sts.quot_zero = (q_step == '0);
        sts.fits      = (cap_reg > ritoa_pkg::CAP_W'(len));
        sts.idx_zero  = (idx_reg == '0);
        sts.out_free  = out_free;
    end

    // Control counters, config register and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            cap_reg       <= ritoa_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end

            if (cmd.load_in)
            begin
                iter_reg <= '0;
                cnt_reg  <= '0;
            end
            else if (cmd.div_step)
            begin
                if (div_last)
                begin
                    iter_reg <= '0;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end

            if (cmd.idx_init)
            begin
                idx_reg <= ADDR_W'(cnt_reg - 1'b1);
            end
            else if (cmd.emit_digit)
            begin
                idx_reg <= idx_reg - 1'b1;
            end

            if (cmd.emit_digit || cmd.emit_error)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Operand and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            d_reg    <= WPAD'(mag);
            rem_reg  <= '0;
            base_reg <= item_base;
            neg_reg  <= in_neg;
        end
        else if (cmd.div_step)
        begin
            d_reg   <= q_step;
            rem_reg <= div_last ? '0 : r_step;
        end
    end

    // Digit store, least significant digit at address zero
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && div_last)
        begin
            digit_mem[cnt_reg[ADDR_W-1:0]] <= r_step;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= digit_mem[idx_reg];
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (cmd.emit_digit)
        begin
            out_ch_reg   <= ritoa_pkg::digit_char(rd_data_reg);
            out_neg_reg  <= neg_reg;
            out_last_reg <= (idx_reg == '0);
            out_err_reg  <= 1'b0;
            out_len_reg  <= (idx_reg == '0) ? len : '0;
        end
        else if (cmd.emit_error)
        begin
            out_ch_reg   <= ritoa_pkg::CHAR_NONE;
            out_neg_reg  <= 1'b0;
            out_last_reg <= 1'b1;
            out_err_reg  <= 1'b1;
            out_len_reg  <= '0;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.ch       = out_ch_reg;
    assign result.negative = out_neg_reg;
    assign result.last     = out_last_reg;
    assign result.error    = out_err_reg;
    assign result.length   = out_len_reg;

endmodule

`default_nettype wire

/* hdl/ritoa_ctrl.sv */
`default_nettype none

module ritoa_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire ritoa_pkg::ritoa_sts_t  sts,
    output ritoa_pkg::ritoa_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_ERR
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = sts.base_ok ? ST_DIV : ST_ERR;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last && sts.quot_zero)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.fits)
                begin
                    cmd.idx_init = 1'b1;
                    state_next   = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_ERR;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    state_next     = sts.idx_zero ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_error = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/radix_integer_to_ascii.sv */
// Channel   Dir   Payload                                   Transfer
// item      in    value[64], is_signed, base[6]             valid & ready
// result    out   ch[8], negative, last, error, length[7]   valid & ready
// cfg       in    cfg_wr_data[8] (buffer_capacity)          cfg_wr_en
//
// One item at a time. Each digit is computed in the shared 4-bit-per-cycle
// divider; each character then passes from the digit RAM through a registered
// read and the result register. The next item is taken while the last
// character still waits in the result register. A stalled result holds the
// emitter; reset is asynchronous.
`default_nettype none

module radix_integer_to_ascii #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ritoa_in_if.sink                            item,
    ritoa_out_if.source                         result,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ritoa_pkg::CAP_W-1:0]    cfg_wr_data
);

    ritoa_pkg::ritoa_cmd_t cmd;
    ritoa_pkg::ritoa_sts_t sts;

    ritoa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    ritoa_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .item_value     (item.value),
        .item_is_signed (item.is_signed),
        .item_base      (item.base),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .result         (result)
    );

endmodule

`default_nettype wire

/* hdl/ritoa_checker.sv */
`default_nettype none

`include "radix_integer_to_ascii_assert.svh"

module ritoa_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    input  wire logic                           item_ready,
    input  wire logic                           result_valid,
    input  wire logic                           result_ready,
    input  wire logic [ritoa_pkg::CHAR_W-1:0]   ch,
    input  wire logic                           negative,
    input  wire logic                           last,
    input  wire logic                           error,
    input  wire logic [ritoa_pkg::LEN_W-1:0]    length
);

    // Stalled result holds its payload
    `RITOA_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(ch) && $stable(last) && $stable(error) && $stable(length) && $stable(negative))

    // Error result is a single bare terminating transfer
    `RITOA_ASSERT_NOW(a_error_shape, clk, rst_n, result_valid && error, last && (ch == ritoa_pkg::CHAR_NONE) && !negative && (length == '0))

    // Digit characters only, length only on the last one
    `RITOA_ASSERT_NOW(a_digit_char, clk, rst_n, result_valid && !error, ((ch >= ritoa_pkg::CHAR_ZERO) && (ch <= ritoa_pkg::CHAR_NINE)) || ((ch >= ritoa_pkg::CHAR_LET_A) && (ch <= ritoa_pkg::CHAR_LET_Z)))
    `RITOA_ASSERT_NOW(a_length_on_last, clk, rst_n, result_valid && !error, last ? (length != '0) : (length == '0))

    // One conversion at a time: input closes after a transfer
    `RITOA_ASSERT_NEXT(a_item_closes, clk, rst_n, item_valid && item_ready, !item_ready)

endmodule

bind radix_integer_to_ascii ritoa_checker u_ritoa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .ch           (result.ch),
    .negative     (result.negative),
    .last         (result.last),
    .error        (result.error),
    .length       (result.length)
);

`default_nettype wire

/* sim/tb_radix_integer_to_ascii.sv */
`default_nettype none

module tb_radix_integer_to_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          VALUE_BITS  = 64;
    localparam logic [63:0] VALUE_MASK  = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam logic [63:0] ALL_ONES    = {64{1'b1}};
    localparam logic [63:0] MOST_NEG    = 64'h1 << (VALUE_BITS - 1);
    localparam int          MAX_DIGITS  = 64;
    localparam int          STALL_LIMIT = 20000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_TAIL  = 60;

    // One character of converted text as seen on the result channel
    typedef struct {
        logic [ritoa_pkg::CHAR_W-1:0] ch;
        logic                         negative;
        logic                         last;
        logic                         error;
        logic [ritoa_pkg::LEN_W-1:0]  length;
    } char_rec_t;

    // Expected text per accepted number, compared in order against the output
    class text_scoreboard;
        char_rec_t                    expected_q[$];
        int unsigned                  errors;
        logic [ritoa_pkg::CAP_W-1:0]  capacity;

        function new();
            errors   = 0;
            capacity = ritoa_pkg::CAP_RESET;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Convert one accepted number into the characters it should produce
        function void note_item(logic [63:0] value, logic is_signed,
                                logic [ritoa_pkg::BASE_W-1:0] base);
            logic [63:0]                   mag;
            logic [63:0]                   radix;
            logic                          neg;
            logic [ritoa_pkg::DIGIT_W-1:0] digs[MAX_DIGITS];
            logic [ritoa_pkg::DIGIT_W-1:0] d;
            int unsigned                   ndig;
            int unsigned                   text_len;
            char_rec_t                     rec;

            rec.ch       = ritoa_pkg::CHAR_NONE;
            rec.negative = 1'b0;
            rec.last     = 1'b1;
            rec.error    = 1'b1;
            rec.length   = '0;
            if (base < ritoa_pkg::BASE_MIN || base > ritoa_pkg::BASE_MAX)
            begin
                expected_q.push_back(rec);
                return;
            end

            mag = value & VALUE_MASK;
            neg = is_signed && mag[VALUE_BITS-1];
            if (neg)
            begin
                mag = (~mag + 64'd1) & VALUE_MASK;
            end

            // Least significant digit first
            radix = 64'(base);
            ndig  = 0;
            do
            begin
                digs[ndig] = ritoa_pkg::DIGIT_W'(mag % radix);
                ndig++;
                mag = mag / radix;
            end
            while (mag != 0 && ndig < MAX_DIGITS);

            text_len = ndig + (neg ? 1 : 0);
            if (int'(capacity) <= text_len)
            begin
                expected_q.push_back(rec);
                return;
            end

            // Emit most significant digit first
            for (int k = 0; k < ndig; k++)
            begin
                d            = digs[ndig - 1 - k];
                rec.ch       = (d < ritoa_pkg::DEC_LIMIT)
                               ? ritoa_pkg::CHAR_ZERO + ritoa_pkg::CHAR_W'(d)
                               : ritoa_pkg::CHAR_ALPHA + ritoa_pkg::CHAR_W'(d);
                rec.negative = neg;
                rec.last     = (k == ndig - 1);
                rec.error    = 1'b0;
                rec.length   = rec.last ? ritoa_pkg::LEN_W'(text_len) : '0;
                expected_q.push_back(rec);
            end
        endfunction

        function void check_char(char_rec_t got);
            char_rec_t want;

            if (expected_q.size() == 0)
            begin
                $error("unexpected result: ch=%h last=%0b error=%0b", got.ch, got.last,
                       got.error);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.ch !== want.ch)
            begin
                $error("ch: expected %h, actual %h", want.ch, got.ch);
                errors++;
            end
            if (got.negative !== want.negative)
            begin
                $error("negative: expected %0b, actual %0b", want.negative, got.negative);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
            if (got.error !== want.error)
            begin
                $error("error: expected %0b, actual %0b", want.error, got.error);
                errors++;
            end
            if (got.length !== want.length)
            begin
                $error("length: expected %0d, actual %0d", want.length, got.length);
                errors++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [ritoa_pkg::CAP_W-1:0]  cfg_wr_data;

    ritoa_in_if  item_bus();
    ritoa_out_if result_bus();

    text_scoreboard sb;

    bit          send_burst;
    bit          recv_burst;
    bit          hold_request;
    int unsigned quiet_cycles;

    radix_integer_to_ascii #(
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_bus),
        .result      (result_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 125 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one number, note it once the transfer happens
    task automatic send_item(logic [63:0] value, logic is_signed,
                             logic [ritoa_pkg::BASE_W-1:0] base);
        int unsigned gap;

        if ($urandom_range(0, 15) == 0)
        begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.value     <= value;
        item_bus.is_signed <= is_signed;
        item_bus.base      <= base;
        @(posedge clk);
        while (!item_bus.ready)
        begin
            @(posedge clk);
        end
        sb.note_item(value, is_signed, base);
    endtask

    // Stop offering and wait until all text has come out
    task automatic drain();
        item_bus.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
    endtask

    // Capacity changes only with the block idle
    task automatic set_capacity(logic [ritoa_pkg::CAP_W-1:0] cap);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.capacity = cap;
    endtask

    // Random numbers, mostly valid bases, with a spread of magnitudes
    task automatic convert_random(int unsigned n, int hold_at);
        logic [63:0]                  v;
        logic                         s;
        logic [ritoa_pkg::BASE_W-1:0] b;
        int unsigned                  nbits;

        for (int i = 0; i < n; i++)
        begin
            if (i == hold_at)
            begin
                hold_request = 1'b1;
            end
            s = $urandom_range(0, 1);
            case ($urandom_range(0, 15))
                0:       v = '0;
                1:       v = ALL_ONES;
                2:       v = MOST_NEG;
                3:       v = ~MOST_NEG;
                default:
                begin
                    nbits = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 10);
                    v     = {$urandom, $urandom};
                    if (nbits < 64)
                    begin
                        v = v & ((64'd1 << nbits) - 64'd1);
                    end
                    if (s && $urandom_range(0, 1))
                    begin
                        v = -v;
                    end
                end
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                b = ritoa_pkg::BASE_W'($urandom_range(0, 63));
            end
            else
            begin
                b = ritoa_pkg::BASE_W'($urandom_range(ritoa_pkg::BASE_MIN,
                                                      ritoa_pkg::BASE_MAX));
            end
            send_item(v, s, b);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned stall;

        result_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 15) == 0)
            begin
                recv_burst = !recv_burst;
            end
            stall = recv_burst ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(result_bus.valid && result_bus.ready));
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        char_rec_t got;

        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.ch       = result_bus.ch;
            got.negative = result_bus.negative;
            got.last     = result_bus.last;
            got.error    = result_bus.error;
            got.length   = result_bus.length;
            sb.check_char(got);
        end
    end

    // Watchdog: too long without any transfer on either channel
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence
    initial
    begin
        sb           = new();
        send_burst   = 1'b0;
        recv_burst   = 1'b0;
        hold_request = 1'b0;

        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        item_bus.valid     <= 1'b0;
        item_bus.value     <= '0;
        item_bus.is_signed <= 1'b0;
        item_bus.base      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bad bases, widest texts, zero, digit/letter boundaries
        send_item(64'd5, 1'b0, 6'd0);
        send_item(64'd5, 1'b0, 6'd1);
        send_item(64'd5, 1'b1, 6'd37);
        send_item(ALL_ONES, 1'b1, 6'd63);
        send_item(ALL_ONES, 1'b0, 6'd2);
        send_item(ALL_ONES, 1'b1, 6'd2);
        send_item(MOST_NEG, 1'b1, 6'd2);
        send_item(MOST_NEG, 1'b0, 6'd2);
        send_item(64'd0, 1'b1, 6'd10);
        send_item(64'd0, 1'b0, 6'd36);
        send_item(ALL_ONES, 1'b0, 6'd36);
        send_item(64'd35, 1'b0, 6'd36);
        send_item(64'd10, 1'b0, 6'd11);
        send_item(64'd9, 1'b1, 6'd10);
        send_item(64'h0123_4567_89AB_CDEF, 1'b0, 6'd16);
        send_item(ALL_ONES, 1'b0, 6'd10);
        send_item(~MOST_NEG, 1'b1, 6'd10);
        send_item(MOST_NEG, 1'b1, 6'd10);
        send_item(64'hFEDC_BA98_7654_3210, 1'b1, 6'd8);
        send_item(64'h5555_AAAA_3333_CCCC, 1'b0, 6'd3);

        // Capacity equal to the length of the longest signed text, which then does not fit
        set_capacity(8'd65);
        send_item(MOST_NEG, 1'b1, 6'd2);
        send_item(ALL_ONES, 1'b0, 6'd2);

        // Random phases across capacity settings
        set_capacity(8'd255);
        convert_random(60, 20);
        set_capacity(8'd0);
        convert_random(15, -1);
        set_capacity(8'd1);
        convert_random(15, -1);
        set_capacity(8'd2);
        convert_random(30, -1);
        set_capacity(ritoa_pkg::CAP_W'($urandom_range(3, 24)));
        convert_random(50, -1);
        set_capacity(ritoa_pkg::CAP_RESET);
        convert_random(60, -1);
        set_capacity(ritoa_pkg::CAP_W'($urandom_range(0, 255)));
        convert_random(50, -1);
        set_capacity(8'd65);
        convert_random(30, -1);

        drain();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
